@@ sv/tpc_pkg.sv @@
// Package for the tape pulse classifier: table widths, register indexes,
// mode codes and small helpers for packed tables and saturation.
// No dependencies; used by tape_pulse_classifier.
package tpc_pkg;

  localparam int LEN_BITS    = 16;
  localparam int MAX_CLASSES = 4;
  localparam int CLS_W       = $clog2(MAX_CLASSES);
  localparam int TBL_W       = MAX_CLASSES * LEN_BITS;
  localparam int THR_W       = (MAX_CLASSES - 1) * LEN_BITS;
  // Signed width for window distances: two lengths below zero, plus sign.
  localparam int D_W         = LEN_BITS + 3;
  // Width of a length times the ratio constants (at most 150 < 2^8).
  localparam int MUL_W       = LEN_BITS + 8;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDEAL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRICT_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRICT_HI  = 3'd5;

  localparam logic [1:0] MODE_THRESHOLD = 2'd0;
  localparam logic [1:0] MODE_ADAPTIVE  = 2'd1;
  localparam logic [1:0] MODE_STRICT    = 2'd2;
  // The spare mode code behaves as strict mode.
  localparam logic [1:0] MODE_SPARE     = 2'd3;

  localparam logic [2:0] NUM_CLASS_RESET = 3'd2;

  // A pulse percentage floor(raw*100/nom) above 50 is raw*100 >= 51*nom,
  // and one below 150 is raw*100 < 150*nom.
  localparam int RATIO_SCALE = 100;
  localparam int RATIO_LO    = 51;
  localparam int RATIO_HI    = 150;

  typedef logic [LEN_BITS-1:0]      len_t;
  typedef logic signed [D_W-1:0]    dist_t;
  typedef logic [CLS_W-1:0]         cls_t;

  localparam dist_t DIST_ONE = dist_t'(1);

  function automatic len_t tbl_entry(logic [TBL_W-1:0] tbl, cls_t idx);
    return tbl[idx*LEN_BITS +: LEN_BITS];
  endfunction

  function automatic dist_t to_dist(len_t v);
    return $signed({{(D_W-LEN_BITS){1'b0}}, v});
  endfunction

  function automatic len_t sat_len(dist_t v);
    dist_t lim;
    lim = to_dist({LEN_BITS{1'b1}});
    if (v > lim) begin
      return {LEN_BITS{1'b1}};
    end else if (v < 0) begin
      return '0;
    end
    return v[LEN_BITS-1:0];
  endfunction

endpackage

@@ sv/tape_pulse_classifier.sv @@
// Tape pulse classifier top level: configuration registers, learned
// tolerances and a class-walking sequencer around one compare unit.
// Depends on tpc_pkg.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | raw_length, force_strict, clear_learned
//  out_    | output    | out_valid/out_stall| pulse_class, class_valid
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// Each item is classed by a walk over the classes: one class per cycle in
// threshold and strict mode, a lower and an upper window step (ST_ADPL,
// ST_ADPH) per class in adaptive mode. The input stalls from acceptance
// until the result is loaded into the output register, so the next item can
// be accepted in the cycle after that; a result waits there while out_stall
// is high. Reset is synchronous, active low, and zeroes the learned tables.
module tape_pulse_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tpc_pkg::LEN_BITS-1:0]   in_raw_length,
  input  logic                           in_force_strict,
  input  logic                           in_clear_learned,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_pulse_class,
  output logic                           out_class_valid,
  input  logic                           cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_THR, ST_STR, ST_ADP0, ST_ADPL, ST_ADPH, ST_ADPEND, ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]                  mode_r;
  logic [2:0]                  num_class_r;
  logic [tpc_pkg::TBL_W-1:0]   ideal_r;
  logic [tpc_pkg::THR_W-1:0]   thr_r;
  logic [tpc_pkg::TBL_W-1:0]   strict_lo_r;
  logic [tpc_pkg::TBL_W-1:0]   strict_hi_r;

  tpc_pkg::len_t  lb_r  [tpc_pkg::MAX_CLASSES];
  tpc_pkg::len_t  lb_nxt[tpc_pkg::MAX_CLASSES];
  tpc_pkg::len_t  la_r  [tpc_pkg::MAX_CLASSES];
  tpc_pkg::len_t  la_nxt[tpc_pkg::MAX_CLASSES];

  tpc_pkg::len_t  raw_r, raw_nxt;
  tpc_pkg::cls_t  p_r, p_nxt;
  tpc_pkg::dist_t dlow_r, dlow_nxt;
  tpc_pkg::cls_t  res_cls_r, res_cls_nxt;
  logic           res_ok_r, res_ok_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_cls_r, out_cls_nxt;
  logic           out_ok_r, out_ok_nxt;

  logic           accept;
  tpc_pkg::cls_t  n_last;
  tpc_pkg::cls_t  p_inc;
  tpc_pkg::cls_t  nom_idx;
  tpc_pkg::cls_t  lb_idx;
  tpc_pkg::len_t  nom;
  tpc_pkg::len_t  la_p;
  tpc_pkg::len_t  lb_q;
  tpc_pkg::len_t  thr_p;
  tpc_pkg::len_t  sb_p;
  tpc_pkg::len_t  sa_p;
  tpc_pkg::dist_t d_lo;
  tpc_pkg::dist_t d_hi;
  logic           in_window;
  logic [tpc_pkg::MUL_W-1:0] raw_scaled;
  logic [tpc_pkg::MUL_W-1:0] nom_lo;
  logic [tpc_pkg::MUL_W-1:0] nom_hi;

  assign accept          = in_valid && (state_r == ST_IDLE);
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pulse_class = out_cls_r;
  assign out_class_valid = out_ok_r;

  // Class count clamped to 2..MAX_CLASSES, held as the last class index.
  always_comb begin
    if (num_class_r < 3'd2) begin
      n_last = tpc_pkg::CLS_W'(1);
    end else if (num_class_r > 3'(tpc_pkg::MAX_CLASSES)) begin
      n_last = tpc_pkg::CLS_W'(tpc_pkg::MAX_CLASSES - 1);
    end else begin
      n_last = tpc_pkg::CLS_W'(num_class_r - 3'd1);
    end
  end

  assign p_inc   = p_r + tpc_pkg::cls_t'(1);
  assign nom_idx = (state_r == ST_ADPH) ? p_inc : p_r;
  assign lb_idx  = (state_r == ST_ADP0) ? '0 : p_inc;

  // Shared operand selection: one class entry of each table per cycle.
  assign nom   = tpc_pkg::tbl_entry(ideal_r, nom_idx);
  assign thr_p = tpc_pkg::tbl_entry({{tpc_pkg::LEN_BITS{1'b0}}, thr_r}, p_r);
  assign sb_p  = tpc_pkg::tbl_entry(strict_lo_r, p_r);
  assign sa_p  = tpc_pkg::tbl_entry(strict_hi_r, p_r);
  assign la_p  = la_r[p_r];
  assign lb_q  = lb_r[lb_idx];

  assign d_lo = tpc_pkg::to_dist(raw_r) - tpc_pkg::to_dist(nom) - tpc_pkg::to_dist(la_p);
  assign d_hi = tpc_pkg::to_dist(nom) - tpc_pkg::to_dist(lb_q) - tpc_pkg::to_dist(raw_r);

  // raw > nom - below and raw < nom + above, kept unsigned one bit wider.
  assign in_window = ({1'b0, raw_r} + {1'b0, sb_p} > {1'b0, nom}) &&
                     ({1'b0, raw_r} < {1'b0, nom} + {1'b0, sa_p});

  assign raw_scaled = tpc_pkg::MUL_W'(raw_r) * tpc_pkg::MUL_W'(tpc_pkg::RATIO_SCALE);
  assign nom_lo     = tpc_pkg::MUL_W'(nom) * tpc_pkg::MUL_W'(tpc_pkg::RATIO_LO);
  assign nom_hi     = tpc_pkg::MUL_W'(nom) * tpc_pkg::MUL_W'(tpc_pkg::RATIO_HI);

  always_comb begin
    state_nxt     = state_r;
    raw_nxt       = raw_r;
    p_nxt         = p_r;
    dlow_nxt      = dlow_r;
    res_cls_nxt   = res_cls_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r;
    out_cls_nxt   = out_cls_r;
    out_ok_nxt    = out_ok_r;
    lb_nxt        = lb_r;
    la_nxt        = la_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          raw_nxt     = in_raw_length;
          p_nxt       = '0;
          res_cls_nxt = '0;
          res_ok_nxt  = 1'b0;
          if (in_clear_learned) begin
            for (int i = 0; i < tpc_pkg::MAX_CLASSES; i++) begin
              lb_nxt[i] = '0;
              la_nxt[i] = '0;
            end
          end
          if (in_force_strict || mode_r > tpc_pkg::MODE_ADAPTIVE) begin
            state_nxt = ST_STR;
          end else if (mode_r == tpc_pkg::MODE_ADAPTIVE) begin
            state_nxt = ST_ADP0;
          end else begin
            state_nxt = ST_THR;
          end
        end
      end
      ST_THR: begin
        if (p_r == n_last || raw_r < thr_p) begin
          res_cls_nxt = p_r;
          res_ok_nxt  = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          p_nxt = p_inc;
        end
      end
      ST_STR: begin
        if (in_window) begin
          res_cls_nxt = p_r;
          res_ok_nxt  = 1'b1;
          state_nxt   = ST_DONE;
        end else if (p_r == n_last) begin
          state_nxt = ST_DONE;
        end else begin
          p_nxt = p_inc;
        end
      end
      ST_ADP0: begin
        // Below the first window: only the lower ratio limit can save it.
        if ({1'b0, raw_r} + {1'b0, lb_q} < {1'b0, nom}) begin
          if (raw_scaled >= nom_lo) begin
            lb_nxt[0]  = tpc_pkg::sat_len(tpc_pkg::to_dist(nom) -
                                          tpc_pkg::to_dist(raw_r) + tpc_pkg::DIST_ONE);
            res_ok_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ADPL;
        end
      end
      ST_ADPL: begin
        if (d_lo < 0) begin
          res_cls_nxt = p_r;
          res_ok_nxt  = 1'b1;
          state_nxt   = ST_DONE;
        end else if (p_r == n_last) begin
          state_nxt = ST_ADPEND;
        end else begin
          dlow_nxt  = d_lo;
          state_nxt = ST_ADPH;
        end
      end
      ST_ADPH: begin
        // Between two windows the nearer one grows toward the pulse.
        if (d_hi > dlow_r) begin
          la_nxt[p_r] = tpc_pkg::sat_len(tpc_pkg::to_dist(la_p) + dlow_r +
                                         tpc_pkg::DIST_ONE);
          res_cls_nxt = p_r;
          res_ok_nxt  = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          p_nxt = p_inc;
          if (d_hi >= 0) begin
            lb_nxt[p_inc] = tpc_pkg::sat_len(tpc_pkg::to_dist(lb_q) + d_hi +
                                             tpc_pkg::DIST_ONE);
            res_cls_nxt   = p_inc;
            res_ok_nxt    = 1'b1;
            state_nxt     = ST_DONE;
          end else begin
            state_nxt = ST_ADPL;
          end
        end
      end
      ST_ADPEND: begin
        if (nom != '0 && raw_scaled < nom_hi) begin
          la_nxt[p_r] = tpc_pkg::sat_len(tpc_pkg::to_dist(raw_r) -
                                         tpc_pkg::to_dist(nom) + tpc_pkg::DIST_ONE);
          res_cls_nxt = p_r;
          res_ok_nxt  = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cls_nxt   = res_ok_r ? 2'(res_cls_r) : 2'd0;
          out_ok_nxt    = res_ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= tpc_pkg::MODE_THRESHOLD;
      num_class_r <= tpc_pkg::NUM_CLASS_RESET;
      ideal_r     <= '0;
      thr_r       <= '0;
      strict_lo_r <= '0;
      strict_hi_r <= '0;
      for (int i = 0; i < tpc_pkg::MAX_CLASSES; i++) begin
        lb_r[i] <= '0;
        la_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lb_r        <= lb_nxt;
      la_r        <= la_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tpc_pkg::REG_MODE:      mode_r      <= cfg_data[1:0];
          tpc_pkg::REG_NUM_CLASS: num_class_r <= cfg_data[2:0];
          tpc_pkg::REG_IDEAL:     ideal_r     <= cfg_data[tpc_pkg::TBL_W-1:0];
          tpc_pkg::REG_THRESHOLD: thr_r       <= cfg_data[tpc_pkg::THR_W-1:0];
          tpc_pkg::REG_STRICT_LO: strict_lo_r <= cfg_data[tpc_pkg::TBL_W-1:0];
          tpc_pkg::REG_STRICT_HI: strict_hi_r <= cfg_data[tpc_pkg::TBL_W-1:0];
          default: begin
          end
        endcase
      end
    end
    raw_r     <= raw_nxt;
    p_r       <= p_nxt;
    dlow_r    <= dlow_nxt;
    res_cls_r <= res_cls_nxt;
    res_ok_r  <= res_ok_nxt;
    out_cls_r <= out_cls_nxt;
    out_ok_r  <= out_ok_nxt;
  end

endmodule

@@ sv/tpc_checker.sv @@
// Port-level checks for the tape pulse classifier, bound to its top level.
// Depends on tape_pulse_classifier.
module tpc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [1:0]                     out_pulse_class,
  input logic                           out_class_valid
);

  // An accepted item keeps the input busy while it is classed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // A rejected pulse always reports class zero.
  a_reject_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_class_valid) |-> (out_pulse_class == 2'd0))
    else $error("rejected item with nonzero class");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_pulse_class) && $stable(out_class_valid)))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind tape_pulse_classifier tpc_checker u_tpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pulse_class (out_pulse_class),
  .out_class_valid (out_class_valid)
);
